### sv/gsm_pkg.sv
// Shared types and constants of the Gaussian-Sobel edge magnitude block.
package gsm_pkg;

  localparam int PIX_W = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;

  localparam logic REG_WIDTH = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [3:0] GAUSS_W [5][5] = '{
    '{4'd2, 4'd4, 4'd5, 4'd4, 4'd2},
    '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9, 4'd12, 4'd9, 4'd4},
    '{4'd2, 4'd4, 4'd5, 4'd4, 4'd2}
  };

  localparam int ROW_SUM_W = 14;
  localparam int BLUR_SUM_W = 16;
  localparam logic [17:0] BLUR_DIV_MUL = 18'd211035;
  localparam int BLUR_DIV_SHIFT = 25;
  localparam int BLUR_PROD_W = 34;

  localparam int FIRST_BLUR = 4;
  localparam int FIRST_EDGE = 6;
  localparam int MIN_DIM = 8;

  typedef struct packed {
    logic emit;
    logic last;
    logic rb;
  } blur_tag_t;

endpackage

### sv/gsm_pixel_if.sv
// Handshake channel of raster-order input pixels.
interface gsm_pixel_if;
  logic valid;
  logic ready;
  logic [7:0] pixel;
  logic frame_start;
  modport source(output valid, output pixel, output frame_start, input ready);
  modport sink(input valid, input pixel, input frame_start, output ready);
endinterface

### sv/gsm_mag_if.sv
// Handshake channel of gradient magnitude results.
interface gsm_mag_if;
  logic valid;
  logic ready;
  logic [7:0] magnitude;
  logic frame_last;
  modport source(output valid, output magnitude, output frame_last, input ready);
  modport sink(input valid, input magnitude, input frame_last, output ready);
endinterface

### sv/gsm_front.sv
// Front end: raster counters, raw line store, 5x5 window and Gaussian blur pipeline.
module gsm_front #(
  parameter int MAX_WIDTH = 128,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = (CW + 1 > 8) ? CW + 1 : 8
) (
  input  logic clk,
  input  logic rst,
  gsm_pixel_if.sink pixels,
  input  logic [7:0] frame_width,
  input  logic [9:0] frame_height,
  output logic push_valid,
  input  logic push_ready,
  output logic [7:0] push_blur,
  output gsm_pkg::blur_tag_t push_tag,
  output logic [CW-1:0] push_col
);

  logic en;
  logic acc;
  logic [CW-1:0] col_count;
  logic [9:0] row_count;
  logic [WW-1:0] wc;
  logic [WW-1:0] fw_ext;
  logic [9:0] hc;
  logic [9:0] r;
  logic [CW-1:0] c;
  logic col_end;
  logic row_end;
  logic [31:0] raw_mem [MAX_WIDTH];

  logic [31:0] raw_rd;
  logic f1_valid;
  logic [7:0] f1_px;
  logic [1:0] f1_rsel;
  logic f1_gv;
  gsm_pkg::blur_tag_t f1_tag;
  logic [CW-1:0] f1_bc;

  logic [7:0] win [5][5];
  logic [7:0] col_new [5];

  logic f2_valid;
  gsm_pkg::blur_tag_t f2_tag;
  logic [CW-1:0] f2_bc;
  logic f3_valid;
  gsm_pkg::blur_tag_t f3_tag;
  logic [CW-1:0] f3_bc;
  logic [gsm_pkg::ROW_SUM_W-1:0] row_sum [5];
  logic [gsm_pkg::ROW_SUM_W-1:0] f3_row [5];
  logic f4_valid;
  gsm_pkg::blur_tag_t f4_tag;
  logic [CW-1:0] f4_bc;
  logic [gsm_pkg::BLUR_SUM_W-1:0] f4_sum;
  logic [gsm_pkg::BLUR_PROD_W-1:0] prod;
  logic f5_valid;
  gsm_pkg::blur_tag_t f5_tag;
  logic [CW-1:0] f5_bc;
  logic [7:0] f5_q;

  assign en = push_ready;
  assign pixels.ready = en;
  assign acc = pixels.valid && en;

  always_comb begin
    fw_ext = WW'(frame_width);
    if (fw_ext < WW'(gsm_pkg::MIN_DIM)) begin
      wc = WW'(gsm_pkg::MIN_DIM);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      wc = WW'(MAX_WIDTH);
    end else begin
      wc = fw_ext;
    end
    hc = (frame_height < 10'(gsm_pkg::MIN_DIM)) ? 10'(gsm_pkg::MIN_DIM) : frame_height;
    r = pixels.frame_start ? '0 : row_count;
    c = pixels.frame_start ? '0 : col_count;
    col_end = (WW'(c) + WW'(1)) >= wc;
    row_end = ({1'b0, r} + 11'd1) >= {1'b0, hc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : r + 10'd1;
      end else begin
        col_count <= c + CW'(1);
        row_count <= r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      raw_rd <= raw_mem[c];
      raw_mem[c][8*r[1:0] +: 8] <= pixels.pixel;
      f1_px <= pixels.pixel;
      f1_rsel <= r[1:0];
      f1_gv <= (r >= 10'(gsm_pkg::FIRST_BLUR)) && (c >= CW'(gsm_pkg::FIRST_BLUR));
      f1_tag.emit <= (r >= 10'(gsm_pkg::FIRST_EDGE)) && (c >= CW'(gsm_pkg::FIRST_EDGE));
      f1_tag.last <= (r == hc - 10'd1) && (WW'(c) == wc - WW'(1));
      f1_tag.rb <= r[0];
      f1_bc <= c - CW'(2);
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col_new[k] = raw_rd[8*(2'(f1_rsel + 2'(k))) +: 8];
    end
    col_new[4] = f1_px;
    for (int k = 0; k < 5; k++) begin
      row_sum[k] = '0;
      for (int l = 0; l < 5; l++) begin
        row_sum[k] = row_sum[k] + gsm_pkg::ROW_SUM_W'(gsm_pkg::GAUSS_W[k][l]) *
                     gsm_pkg::ROW_SUM_W'(win[k][l]);
      end
    end
    prod = gsm_pkg::BLUR_PROD_W'(f4_sum) * gsm_pkg::BLUR_PROD_W'(gsm_pkg::BLUR_DIV_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
      f4_valid <= 1'b0;
      f5_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= pixels.valid;
      f2_valid <= f1_valid && f1_gv;
      f3_valid <= f2_valid;
      f4_valid <= f3_valid;
      f5_valid <= f4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f1_valid) begin
        for (int k = 0; k < 5; k++) begin
          for (int l = 0; l < 4; l++) begin
            win[k][l] <= win[k][l+1];
          end
          win[k][4] <= col_new[k];
        end
      end
      f2_tag <= f1_tag;
      f2_bc <= f1_bc;
      f3_tag <= f2_tag;
      f3_bc <= f2_bc;
      f3_row <= row_sum;
      f4_tag <= f3_tag;
      f4_bc <= f3_bc;
      f4_sum <= gsm_pkg::BLUR_SUM_W'(f3_row[0]) + gsm_pkg::BLUR_SUM_W'(f3_row[1]) +
                gsm_pkg::BLUR_SUM_W'(f3_row[2]) + gsm_pkg::BLUR_SUM_W'(f3_row[3]) +
                gsm_pkg::BLUR_SUM_W'(f3_row[4]);
      f5_tag <= f4_tag;
      f5_bc <= f4_bc;
      f5_q <= prod[gsm_pkg::BLUR_DIV_SHIFT +: 8];
    end
  end

  assign push_valid = f5_valid && en;
  assign push_blur = f5_q;
  assign push_tag = f5_tag;
  assign push_col = f5_bc;

endmodule

### sv/gsm_queue.sv
// Short item queue between the blur front end and the gradient back end.
module gsm_queue #(
  parameter int W = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [W-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = $clog2(gsm_pkg::QUEUE_DEPTH);

  logic [W-1:0] slots [gsm_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic push;
  logic pop;

  assign push_ready = count < (AW+1)'(gsm_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(gsm_pkg::QUEUE_DEPTH)) else $error("queue count overflow");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (AW+1)'(1)) else $error("queue push lost");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - (AW+1)'(1)) else $error("queue pop lost");
`endif

endmodule

### sv/gsm_back.sv
// Back end: blur line store, 3x3 Sobel window, clamped magnitude and square root.
module gsm_back #(
  parameter int MAX_WIDTH = 128,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic clk,
  input  logic rst,
  input  logic pop_valid,
  output logic pop_ready,
  input  logic [7:0] blur,
  input  gsm_pkg::blur_tag_t tag,
  input  logic [CW-1:0] col,
  gsm_mag_if.source edges
);

  typedef struct packed {
    logic [11:0] rem;
    logic [7:0] root;
  } sqrt_state_t;

  function automatic sqrt_state_t sqrt_steps(input sqrt_state_t s, input logic [7:0] bits);
    sqrt_state_t t;
    logic [11:0] trial;
    t = s;
    for (int i = 3; i >= 0; i--) begin
      t.rem = {t.rem[9:0], bits[2*i +: 2]};
      trial = {2'b00, t.root, 2'b01};
      if (t.rem >= trial) begin
        t.rem = t.rem - trial;
        t.root = {t.root[6:0], 1'b1};
      end else begin
        t.root = {t.root[6:0], 1'b0};
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] abs_clamp(input logic signed [10:0] g);
    logic [10:0] a;
    a = g[10] ? 11'(-g) : 11'(g);
    return (a > 11'(gsm_pkg::PIXEL_MAX)) ? gsm_pkg::PIXEL_MAX : a[7:0];
  endfunction

  logic en;
  logic take;
  logic [15:0] blur_mem [MAX_WIDTH];
  logic [15:0] blur_rd;
  logic b1_valid;
  logic [7:0] b1_blur;
  gsm_pkg::blur_tag_t b1_tag;
  logic [7:0] bw [3][3];
  logic b2_valid;
  logic b2_last;
  logic b3_valid;
  logic b3_last;
  logic [7:0] b3_a;
  logic [7:0] b3_b;
  logic b4_valid;
  logic b4_last;
  logic [16:0] b4_v;
  logic b5_valid;
  logic b5_last;
  logic b5_sat;
  logic [7:0] b5_low;
  sqrt_state_t b5_s;
  sqrt_state_t s_hi;
  sqrt_state_t s_lo;
  logic signed [10:0] ga;
  logic signed [10:0] gb;

  assign en = !edges.valid || edges.ready;
  assign pop_ready = en;
  assign take = pop_valid && en;

  always_ff @(posedge clk) begin
    if (take) begin
      blur_rd <= blur_mem[col];
      blur_mem[col][8*tag.rb +: 8] <= blur;
      b1_blur <= blur;
      b1_tag <= tag;
    end
  end

  always_comb begin
    ga = (11'(bw[2][0]) + 11'({bw[2][1], 1'b0}) + 11'(bw[2][2])) -
         (11'(bw[0][0]) + 11'({bw[0][1], 1'b0}) + 11'(bw[0][2]));
    gb = (11'(bw[0][2]) + 11'({bw[1][2], 1'b0}) + 11'(bw[2][2])) -
         (11'(bw[0][0]) + 11'({bw[1][0], 1'b0}) + 11'(bw[2][0]));
    s_hi = sqrt_steps('0, b4_v[15:8]);
    s_lo = sqrt_steps(b5_s, b5_low);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
      b4_valid <= 1'b0;
      b5_valid <= 1'b0;
      edges.valid <= 1'b0;
    end else if (en) begin
      b1_valid <= pop_valid;
      b2_valid <= b1_valid && b1_tag.emit;
      b3_valid <= b2_valid;
      b4_valid <= b3_valid;
      b5_valid <= b4_valid;
      edges.valid <= b5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (b1_valid) begin
        for (int k = 0; k < 3; k++) begin
          bw[k][0] <= bw[k][1];
          bw[k][1] <= bw[k][2];
        end
        bw[0][2] <= blur_rd[8*b1_tag.rb +: 8];
        bw[1][2] <= blur_rd[8*(!b1_tag.rb) +: 8];
        bw[2][2] <= b1_blur;
      end
      b2_last <= b1_tag.last;
      b3_last <= b2_last;
      b3_a <= abs_clamp(ga);
      b3_b <= abs_clamp(gb);
      b4_last <= b3_last;
      b4_v <= 17'(b3_a * b3_a) + 17'(b3_b * b3_b);
      b5_last <= b4_last;
      b5_sat <= b4_v[16];
      b5_low <= b4_v[7:0];
      b5_s <= s_hi;
      edges.frame_last <= b5_last;
      edges.magnitude <= b5_sat ? gsm_pkg::PIXEL_MAX : s_lo.root;
    end
  end

endmodule

### sv/gaussian_sobel_edge_magnitude.sv
// Top level: configuration registers, blur front end, item queue and gradient back end.
// Throughput: one pixel item per cycle, sustained, while the result side keeps up.
// Stages: 5 blur stages, the queue, then 6 gradient stages up to the output register.
// Reset (rst, synchronous): clears raster counters, pipeline valids and queue;
// width and height return to 94 and 60. Line stores are not cleared.
module gaussian_sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [9:0] cfg_data,
  gsm_pixel_if.sink pixels,
  gsm_mag_if.source edges
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int TW = $bits(gsm_pkg::blur_tag_t);
  localparam int QW = 8 + TW + CW;

  logic [7:0] frame_width;
  logic [9:0] frame_height;
  logic push_valid;
  logic push_ready;
  logic [7:0] push_blur;
  gsm_pkg::blur_tag_t push_tag;
  logic [CW-1:0] push_col;
  logic pop_valid;
  logic pop_ready;
  logic [QW-1:0] pop_data;
  gsm_pkg::blur_tag_t pop_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 8'd94;
      frame_height <= 10'd60;
    end else if (cfg_we) begin
      case (cfg_index)
        gsm_pkg::REG_WIDTH: frame_width <= cfg_data[7:0];
        gsm_pkg::REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  gsm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk(clk),
    .rst(rst),
    .pixels(pixels),
    .frame_width(frame_width),
    .frame_height(frame_height),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_blur(push_blur),
    .push_tag(push_tag),
    .push_col(push_col)
  );

  gsm_queue #(.W(QW)) u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data({push_col, push_tag, push_blur}),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_data(pop_data)
  );

  assign pop_tag = pop_data[8 +: TW];

  gsm_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .blur(pop_data[7:0]),
    .tag(pop_tag),
    .col(pop_data[8+TW +: CW]),
    .edges(edges)
  );

endmodule

### tb/gaussian_sobel_edge_magnitude_tb.sv
// Self-checking testbench of the Gaussian-Sobel edge magnitude block, with a pixel-level predictor.
`timescale 1ns / 1ps

module gaussian_sobel_edge_magnitude_tb;

  localparam int MAX_W = 128;
  localparam int DRAIN_CYCLES = 30;
  localparam int SOB_V [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};
  localparam int SOB_H [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};

  typedef enum int {PAT_FLAT_LO, PAT_FLAT_HI, PAT_CHECKER, PAT_VEDGE, PAT_HEDGE,
                    PAT_NOISE, PAT_SMOOTH} pattern_t;

  typedef struct {
    pattern_t pat;
    bit start;
    bit typed;
    logic [7:0] mag;
  } frame_row_t;

  typedef struct {
    logic [7:0] mag;
    logic last;
  } edge_item_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = gsm_pkg::REG_WIDTH;
  logic [9:0] cfg_data = '0;

  gsm_pixel_if pixels_ch();
  gsm_mag_if edges_ch();

  gaussian_sobel_edge_magnitude DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixels(pixels_ch), .edges(edges_ch)
  );

  always #10 clk = ~clk;

  logic [7:0] raw_rows [4][MAX_W];
  logic [7:0] blur_rows [2][MAX_W];
  logic [7:0] raw_win [5][5];
  logic [7:0] blur_win [3][3];
  int col_cnt, row_cnt, width_reg, height_reg;

  edge_item_t expected_edges[$];
  int errors = 0;
  int tx_idle = 0, rx_idle = 0;
  bit hold = 0, hold_req = 0;

  frame_row_t directed[6] = '{
    '{PAT_FLAT_LO, 1'b1, 1'b1, 8'd0},
    '{PAT_FLAT_HI, 1'b1, 1'b1, 8'd0},
    '{PAT_CHECKER, 1'b1, 1'b0, 8'd0},
    '{PAT_VEDGE, 1'b0, 1'b0, 8'd0},
    '{PAT_HEDGE, 1'b1, 1'b0, 8'd0},
    '{PAT_NOISE, 1'b0, 1'b0, 8'd0}
  };

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < gsm_pkg::MIN_DIM) w = gsm_pkg::MIN_DIM;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int eff_height();
    return (height_reg < gsm_pkg::MIN_DIM) ? gsm_pkg::MIN_DIM : height_reg;
  endfunction

  function automatic int clamp_abs(int g);
    int a;
    a = (g < 0) ? -g : g;
    return (a > 255) ? 255 : a;
  endfunction

  function automatic void edge_predict(input logic [7:0] px, input logic st, output bit emit,
                                       output edge_item_t res);
    int w, h, r, c, sum, bc, gv, gh, a, b, s, x, t;
    w = eff_width();
    h = eff_height();
    emit = 0;
    res = '{8'd0, 1'b0};
    if (st) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    r = row_cnt;
    c = col_cnt % MAX_W;
    for (int k = 0; k < 5; k++)
      for (int l = 0; l < 4; l++) raw_win[k][l] = raw_win[k][l+1];
    for (int k = 0; k < 4; k++) raw_win[k][4] = raw_rows[(r + k) & 3][c];
    raw_win[4][4] = px;
    raw_rows[r & 3][c] = px;
    if (r >= gsm_pkg::FIRST_BLUR && c >= gsm_pkg::FIRST_BLUR) begin
      sum = 0;
      bc = c - 2;
      for (int k = 0; k < 5; k++)
        for (int l = 0; l < 5; l++)
          sum += int'(gsm_pkg::GAUSS_W[k][l]) * int'(raw_win[k][l]);
      for (int k = 0; k < 3; k++)
        for (int l = 0; l < 2; l++) blur_win[k][l] = blur_win[k][l+1];
      blur_win[0][2] = blur_rows[r & 1][bc];
      blur_win[1][2] = blur_rows[(r + 1) & 1][bc];
      blur_win[2][2] = 8'(sum / 159);
      blur_rows[r & 1][bc] = 8'(sum / 159);
      if (r >= gsm_pkg::FIRST_EDGE && c >= gsm_pkg::FIRST_EDGE) begin
        gv = 0;
        gh = 0;
        for (int k = 0; k < 3; k++)
          for (int l = 0; l < 3; l++) begin
            gv += SOB_V[k][l] * int'(blur_win[k][l]);
            gh += SOB_H[k][l] * int'(blur_win[k][l]);
          end
        a = clamp_abs(gv);
        b = clamp_abs(gh);
        s = a * a + b * b;
        x = 0;
        for (int bt = 512; bt > 0; bt >>= 1) begin
          t = x | bt;
          if (t * t <= s) x = t;
        end
        res.mag = (x > 255) ? 8'd255 : 8'(x);
        res.last = (r == h - 1 && c == w - 1);
        emit = 1;
      end
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endfunction

  function automatic logic [7:0] pattern_pixel(pattern_t pat, int r, int c, int w, int h);
    case (pat)
      PAT_FLAT_LO: return 8'd0;
      PAT_FLAT_HI: return 8'd255;
      PAT_CHECKER: return ((r ^ c) & 1) ? 8'd255 : 8'd0;
      PAT_VEDGE: return (c < w / 2) ? 8'd0 : 8'd255;
      PAT_HEDGE: return (r < h / 2) ? 8'd255 : 8'd0;
      PAT_SMOOTH: return 8'($urandom_range(90, 150) + 4 * c);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(logic [7:0] px, logic st, bit typed, logic [7:0] typed_mag);
    bit emit;
    edge_item_t res;
    while ($urandom_range(0, 99) < tx_idle) begin
      pixels_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixels_ch.valid <= 1'b1;
    pixels_ch.pixel <= px;
    pixels_ch.frame_start <= st;
    do @(posedge clk); while (!pixels_ch.ready);
    edge_predict(px, st, emit, res);
    if (typed) res.mag = typed_mag;
    if (emit) expected_edges.push_back(res);
  endtask

  task automatic send_frame(pattern_t pat, bit st, int count, bit typed, logic [7:0] typed_mag);
    int w, h;
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < count; i++)
      send_pixel(pattern_pixel(pat, i / w, i % w, w, h), st && i == 0, typed, typed_mag);
  endtask

  task automatic wait_idle();
    pixels_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == gsm_pkg::REG_WIDTH) width_reg = value & 10'hFF;
    else height_reg = value;
  endtask

  task automatic set_frame(logic [9:0] wdata, logic [9:0] hdata);
    wait_idle();
    write_reg(gsm_pkg::REG_WIDTH, wdata);
    write_reg(gsm_pkg::REG_HEIGHT, hdata);
  endtask

  task automatic random_phase(int budget, bit extremes);
    int sent, n, w, h, roll;
    bit fresh;
    sent = 0;
    while (sent < budget) begin
      fresh = 1'b0;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        set_frame(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 12)));
        fresh = 1'b1;
      end else if (roll < 35) begin
        set_frame(10'($urandom_range(8, 16)), 10'($urandom_range(8, 12)));
        fresh = 1'b1;
      end
      w = eff_width();
      h = eff_height();
      n = w * h;
      if (n > 600) n = $urandom_range(80, 200);
      else if ($urandom_range(0, 99) < 8) n = $urandom_range(1, n - 1);
      send_frame(($urandom_range(0, 1) != 0) ? PAT_NOISE : PAT_SMOOTH,
                 fresh || $urandom_range(0, 99) < 90 || n != w * h, n, 1'b0, 8'd0);
      sent += n;
    end
    if (extremes) begin
      set_frame(10'd255, 10'd0);
      send_frame(PAT_NOISE, 1'b1, 128 * 8, 1'b0, 8'd0);
      set_frame(10'd8, 10'd1023);
      send_frame(PAT_SMOOTH, 1'b1, 8 * 12, 1'b0, 8'd0);
      send_frame(PAT_NOISE, 1'b1, 8 * 8, 1'b0, 8'd0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      edges_ch.ready <= 1'b0;
    end else begin
      if (edges_ch.valid && edges_ch.ready) begin
        if (expected_edges.size() == 0) begin
          $display("%0t unexpected item: got mag %0d last %0d", $time,
                   edges_ch.magnitude, edges_ch.frame_last);
          errors++;
        end else begin
          if (edges_ch.magnitude !== expected_edges[0].mag ||
              edges_ch.frame_last !== expected_edges[0].last) begin
            $display("%0t mismatch: expected mag %0d last %0d, got mag %0d last %0d", $time,
                     expected_edges[0].mag, expected_edges[0].last,
                     edges_ch.magnitude, edges_ch.frame_last);
            errors++;
          end
          void'(expected_edges.pop_front());
        end
      end
      edges_ch.ready <= !hold && ($urandom_range(0, 99) >= rx_idle);
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold <= 1'b1;
    repeat (400) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    pixels_ch.valid = 1'b0;
    pixels_ch.pixel = '0;
    pixels_ch.frame_start = 1'b0;
    foreach (raw_rows[i, j]) raw_rows[i][j] = '0;
    foreach (blur_rows[i, j]) blur_rows[i][j] = '0;
    foreach (raw_win[i, j]) raw_win[i][j] = '0;
    foreach (blur_win[i, j]) blur_win[i][j] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = 94;
    height_reg = 60;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_frame(10'd8, 10'd8);
    foreach (directed[i])
      send_frame(directed[i].pat, directed[i].start, 64, directed[i].typed, directed[i].mag);

    tx_idle = 13;
    rx_idle = 79;
    random_phase(100, 1'b0);
    wait_idle();
    tx_idle = 79;
    rx_idle = 13;
    random_phase(100, 1'b0);
    wait_idle();
    tx_idle = 0;
    rx_idle = 0;
    hold_req = 1'b1;
    random_phase(60, 1'b1);

    wait_idle();
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
sv/gsm_pkg.sv
sv/gsm_pixel_if.sv
sv/gsm_mag_if.sv
sv/gsm_front.sv
sv/gsm_queue.sv
sv/gsm_back.sv
sv/gaussian_sobel_edge_magnitude.sv
tb/gaussian_sobel_edge_magnitude_tb.sv
